FILE: hdl/gf2pd_pkg.sv
// Shared types and constants for the GF(2) polynomial divide and gcd block.
package gf2pd_pkg;

  localparam int DEF_WIDTH = 64;  // default coefficient count
  localparam int FIELD_W   = 64;  // width of the polynomial ports

  typedef enum logic [0:0] {
    ACT_DIVIDE = 1'b0,
    ACT_GCD    = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_NORM,
    ST_DIV_RUN,
    ST_GCD_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SHIFT_U,
    DP_SHIFT_V,
    DP_XOR_U,
    DP_XOR_V,
    DP_DIV_STEP,
    DP_FIN_DIV,
    DP_FIN_GCD,
    DP_FIN_ERR
  } dp_op_t;

  typedef struct packed {
    logic u_zero;
    logic v_zero;
    logic u_top;
    logic v_top;
    logic du_ge_dv;
    logic du_lt_dv;
  } dp_stat_t;

endpackage

FILE: hdl/gf2pd_ctrl.sv
// Sequencer for the divide and gcd datapath.
module gf2pd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                action,
  input  gf2pd_pkg::dp_stat_t stat,
  output gf2pd_pkg::dp_op_t   cmd,
  output logic                busy,
  output logic                out_valid
);
  import gf2pd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (action == ACT_GCD) ? ST_GCD_RUN : ST_DIV_NORM;
        end
      end
      ST_DIV_NORM: begin
        if (stat.v_zero) begin
          state_nxt = ST_DONE;
        end else if (stat.v_top) begin
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (stat.du_lt_dv) begin
          state_nxt = ST_DONE;
        end
      end
      ST_GCD_RUN: begin
        if (stat.u_zero || stat.v_zero) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = DP_NOP;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd = DP_LOAD;
        end
      end
      ST_DIV_NORM: begin
        // left-align the divisor first
        if (stat.v_zero) begin
          cmd = DP_FIN_ERR;
        end else if (!stat.v_top) begin
          cmd = DP_SHIFT_V;
        end
      end
      ST_DIV_RUN: begin
        cmd = stat.du_lt_dv ? DP_FIN_DIV : DP_DIV_STEP;
      end
      ST_GCD_RUN: begin
        if (stat.u_zero || stat.v_zero) begin
          cmd = DP_FIN_GCD;
        end else if (!stat.v_top) begin
          cmd = DP_SHIFT_V;
        end else if (!stat.u_top) begin
          cmd = DP_SHIFT_U;
        end else if (stat.du_ge_dv) begin
          cmd = DP_XOR_U;
        end else begin
          cmd = DP_XOR_V;
        end
      end
      ST_DONE:  cmd = DP_NOP;
      default:  cmd = DP_NOP;
    endcase
  end

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not start work");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(cmd) == DP_FIN_DIV || $past(cmd) == DP_FIN_GCD ||
                   $past(cmd) == DP_FIN_ERR))
    else $error("result strobe without a finish step");

endmodule

FILE: hdl/gf2pd_dpath.sv
// Left-aligned shift/XOR datapath: operand registers, degree bounds, quotient, result.
module gf2pd_dpath #(
  parameter int WIDTH = gf2pd_pkg::DEF_WIDTH
) (
  input  logic                             clk,
  input  gf2pd_pkg::dp_op_t                cmd,
  input  logic [gf2pd_pkg::FIELD_W-1:0]    poly_a,
  input  logic [gf2pd_pkg::FIELD_W-1:0]    poly_b,
  output gf2pd_pkg::dp_stat_t              stat,
  output logic [gf2pd_pkg::FIELD_W-1:0]    quotient,
  output logic [gf2pd_pkg::FIELD_W-1:0]    remainder_or_gcd,
  output logic                             status
);
  import gf2pd_pkg::*;

  localparam int DW = $clog2(WIDTH) + 1;

  // u_r/v_r hold each operand shifted up so that bit WIDTH-1 sits at degree du_r/dv_r
  logic [WIDTH-1:0]           u_r, u_nxt, v_r, v_nxt, q_r, q_nxt;
  logic signed [DW-1:0]       du_r, du_nxt, dv_r, dv_nxt;
  logic [FIELD_W-1:0]         oq_r, oq_nxt, or_r, or_nxt;
  logic                       ost_r, ost_nxt;
  logic [DW-1:0]              sh_u, sh_v;
  logic [WIDTH-1:0]           uv_x;

  assign uv_x = u_r ^ v_r;
  assign sh_u = DW'(WIDTH - 1) - du_r;
  assign sh_v = DW'(WIDTH - 1) - dv_r;

  always_comb begin
    stat.u_zero   = (u_r == '0);
    stat.v_zero   = (v_r == '0);
    stat.u_top    = u_r[WIDTH-1];
    stat.v_top    = v_r[WIDTH-1];
    stat.du_ge_dv = (du_r >= dv_r);
    stat.du_lt_dv = (du_r < dv_r);
  end

  always_comb begin
    u_nxt   = u_r;
    v_nxt   = v_r;
    q_nxt   = q_r;
    du_nxt  = du_r;
    dv_nxt  = dv_r;
    oq_nxt  = oq_r;
    or_nxt  = or_r;
    ost_nxt = ost_r;
    case (cmd)
      DP_LOAD: begin
        u_nxt  = poly_a[WIDTH-1:0];
        v_nxt  = poly_b[WIDTH-1:0];
        du_nxt = DW'(WIDTH - 1);
        dv_nxt = DW'(WIDTH - 1);
        q_nxt  = '0;
      end
      DP_SHIFT_U: begin
        u_nxt  = u_r << 1;
        du_nxt = du_r - DW'(1);
      end
      DP_SHIFT_V: begin
        v_nxt  = v_r << 1;
        dv_nxt = dv_r - DW'(1);
      end
      DP_XOR_U: begin
        // leading terms cancel, so drop the top bit
        u_nxt  = uv_x << 1;
        du_nxt = du_r - DW'(1);
      end
      DP_XOR_V: begin
        v_nxt  = uv_x << 1;
        dv_nxt = dv_r - DW'(1);
      end
      DP_DIV_STEP: begin
        u_nxt  = u_r[WIDTH-1] ? (uv_x << 1) : (u_r << 1);
        q_nxt  = {q_r[WIDTH-2:0], u_r[WIDTH-1]};
        du_nxt = du_r - DW'(1);
      end
      DP_FIN_DIV: begin
        oq_nxt  = FIELD_W'(q_r);
        or_nxt  = FIELD_W'(u_r >> sh_u);
        ost_nxt = 1'b0;
      end
      DP_FIN_GCD: begin
        oq_nxt  = '0;
        or_nxt  = stat.v_zero ? FIELD_W'(u_r >> sh_u) : FIELD_W'(v_r >> sh_v);
        ost_nxt = 1'b0;
      end
      DP_FIN_ERR: begin
        oq_nxt  = '0;
        or_nxt  = '0;
        ost_nxt = 1'b1;
      end
      DP_NOP:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    q_r   <= q_nxt;
    du_r  <= du_nxt;
    dv_r  <= dv_nxt;
    oq_r  <= oq_nxt;
    or_r  <= or_nxt;
    ost_r <= ost_nxt;
  end

  assign quotient         = oq_r;
  assign remainder_or_gcd = or_r;
  assign status           = ost_r;

endmodule

FILE: hdl/gf2_poly_divide_and_gcd.sv
// Top level: GF(2) polynomial divider and Euclidean gcd unit.
//
//   channel | handshake                    | payload
//   --------+------------------------------+-------------------------------------------
//   input   | start, busy (transfer when   | in_action, in_poly_a, in_poly_b
//           | start high and busy low)     |
//   result  | out_valid, one-cycle strobe  | out_quotient, out_remainder_or_gcd,
//           |                              | out_status
//
// One item at a time. Divide and gcd proceed by at most one shift/XOR step per cycle on
// the left-aligned operand registers; a zero divisor ends a divide with out_status set.
// busy rises after the transfer and stays high through the strobe cycle.
// Synchronous active-low reset returns the sequencer to idle.
// The receiver cannot stall; each result is shown for exactly one cycle.
module gf2_poly_divide_and_gcd #(
  parameter int WIDTH = gf2pd_pkg::DEF_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [gf2pd_pkg::FIELD_W-1:0] in_poly_a,
  input  logic [gf2pd_pkg::FIELD_W-1:0] in_poly_b,
  output logic                          out_valid,
  output logic [gf2pd_pkg::FIELD_W-1:0] out_quotient,
  output logic [gf2pd_pkg::FIELD_W-1:0] out_remainder_or_gcd,
  output logic                          out_status
);
  import gf2pd_pkg::*;

  dp_op_t   cmd;
  dp_stat_t stat;

  gf2pd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gf2pd_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .poly_a           (in_poly_a),
    .poly_b           (in_poly_b),
    .stat             (stat),
    .quotient         (out_quotient),
    .remainder_or_gcd (out_remainder_or_gcd),
    .status           (out_status)
  );

endmodule
